// ----- design/pse_pkg.sv -----
`default_nettype none

package pse_pkg;

  localparam int unsigned PSE_DIM_BITS  = 14;
  localparam int unsigned PSE_BLOCK_MAX = 65535;

  // configuration register indexes
  localparam logic CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic CFG_IMAGE_HEIGHT = 1'b1;

  localparam logic [31:0] CRC_POLY   = 32'hedb88320;
  localparam logic [31:0] CRC_INIT   = 32'hffffffff;
  localparam logic [15:0] ADLER_MOD  = 16'd65521;
  localparam logic [7:0]  ZLIB_CMF   = 8'h78;
  localparam logic [7:0]  ZLIB_FLG   = 8'h01;
  localparam logic [63:0] PNG_SIG    = 64'h89504e470d0a1a0a;
  localparam logic [31:0] CHUNK_IHDR = 32'h49484452;
  localparam logic [31:0] CHUNK_IDAT = 32'h49444154;
  localparam logic [31:0] CHUNK_IEND = 32'h49454e44;
  localparam logic [7:0]  IHDR_DEPTH = 8'd8;
  localparam logic [7:0]  IHDR_COLOR = 8'd2;
  localparam logic [7:0]  IHDR_LEN   = 8'd13;

  // item classification passed from front to back
  typedef struct packed {
    logic start;
    logic col0;
    logic last;
  } pse_ctl_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

  // both operands below the modulus
  function automatic logic [15:0] adler_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, ADLER_MOD}) begin
      s = s - {1'b0, ADLER_MOD};
    end
    return s[15:0];
  endfunction

endpackage

`default_nettype wire

// ----- design/pse_if.sv -----
`default_nettype none

interface pse_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

interface pse_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       file_last;
  modport source (output valid, output out_byte, output run_last, output file_last, input ready);
  modport sink (input valid, input out_byte, input run_last, input file_last, output ready);
endinterface

`default_nettype wire

// ----- design/png_stored_stream_encoder_core.sv -----
`default_nettype none

// streaming png writer: one rgb pixel per item in raster order in, file bytes out one per
// cycle while the receiver is ready and pixels are waiting. the first pixel of a file also
// produces the signature, ihdr with its crc, the idat length and type and the zlib header
// (43 bytes); every pixel produces its three samples, plus a zero filter byte when it
// opens a row and a 5-byte stored block header each STORED_BLOCK_MAX raw bytes; the pixel
// that ends the image adds adler-32, the idat crc and iend (20 bytes). the byte-wide output
// register sets the rate: a pixel is held until all its bytes are out, and the next is
// taken from the queue with its last byte. the block count in the idat length comes from a
// reciprocal multiply registered when the first pixel is taken, so it is ready in the cycle
// after, long before that length is due. image_width and image_height are sampled on the
// first pixel of a file; a width below 2 is used as 2 and a height of 0 as 1.
module png_stored_stream_encoder_core
  import pse_pkg::*;
#(
  parameter int unsigned DIM_BITS         = PSE_DIM_BITS,
  parameter int unsigned STORED_BLOCK_MAX = PSE_BLOCK_MAX
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  pse_pix_if.sink                  pix_i,
  pse_byte_if.source               byte_o,
  input  wire logic                cfg_we_i,
  input  wire logic                cfg_idx_i,
  input  wire logic [DIM_BITS-1:0] cfg_data_i
);

  localparam int unsigned RAW_W = 2 * DIM_BITS + 2;
  // queue entry: classification, pixel, dimensions, raw byte count
  localparam int unsigned Q_W   = 3 + 24 + 2 * DIM_BITS + RAW_W;

  logic                push, full, pop, qv;
  pse_ctl_t            f_ctl;
  logic [23:0]         f_pix;
  logic [DIM_BITS-1:0] f_w, f_h;
  logic [RAW_W-1:0]    f_raw;
  logic [Q_W-1:0]      q_in, q_out;

  // front: register file, row and column tracking, raw size
  pse_front #(
    .DIM_BITS (DIM_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pix_i      (pix_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .q_full_i   (full),
    .q_push_o   (push),
    .q_ctl_o    (f_ctl),
    .q_pix_o    (f_pix),
    .q_width_o  (f_w),
    .q_height_o (f_h),
    .q_raw_o    (f_raw)
  );

  assign q_in = {f_ctl, f_pix, f_w, f_h, f_raw};

  // two-entry decoupling queue
  pse_queue #(
    .W (Q_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (q_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (qv),
    .data_o  (q_out)
  );

  // back: byte sequencer with crc, adler and stored block framing
  pse_back #(
    .DIM_BITS         (DIM_BITS),
    .STORED_BLOCK_MAX (STORED_BLOCK_MAX)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (qv),
    .q_pop_o    (pop),
    .q_ctl_i    (pse_ctl_t'(q_out[Q_W-1 -: 3])),
    .q_pix_i    (q_out[Q_W-4 -: 24]),
    .q_width_i  (q_out[RAW_W+2*DIM_BITS-1 -: DIM_BITS]),
    .q_height_i (q_out[RAW_W+DIM_BITS-1 -: DIM_BITS]),
    .q_raw_i    (q_out[RAW_W-1:0]),
    .byte_o     (byte_o)
  );

endmodule

`default_nettype wire

// ----- design/pse_front.sv -----
`default_nettype none

module pse_front
  import pse_pkg::*;
#(
  parameter int unsigned DIM_BITS = PSE_DIM_BITS,
  localparam int unsigned RAW_W   = 2 * DIM_BITS + 2
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  pse_pix_if.sink                  pix_i,
  input  wire logic                cfg_we_i,
  input  wire logic                cfg_idx_i,
  input  wire logic [DIM_BITS-1:0] cfg_data_i,
  input  wire logic                q_full_i,
  output logic                     q_push_o,
  output pse_ctl_t                 q_ctl_o,
  output logic [23:0]              q_pix_o,
  output logic [DIM_BITS-1:0]      q_width_o,
  output logic [DIM_BITS-1:0]      q_height_o,
  output logic [RAW_W-1:0]         q_raw_o
);

  logic [DIM_BITS-1:0] width_q, height_q, used_w_q, used_h_q, col_q, row_q;
  logic [DIM_BITS-1:0] w_clamp, h_clamp, w_use, h_use, col_nx, row_nx;
  logic                started_q, start, wrap, last, accept;
  logic [DIM_BITS+1:0] wp1;

  assign w_clamp = (width_q < DIM_BITS'(2)) ? DIM_BITS'(2) : width_q;
  assign h_clamp = (height_q == '0) ? DIM_BITS'(1) : height_q;
  assign start   = !started_q;
  assign w_use   = start ? w_clamp : used_w_q;
  assign h_use   = start ? h_clamp : used_h_q;
  assign col_nx  = col_q + DIM_BITS'(1);
  assign wrap    = (col_nx == w_use);
  assign row_nx  = wrap ? row_q + DIM_BITS'(1) : row_q;
  assign last    = (row_nx == h_use);

  assign pix_i.ready = !q_full_i;
  assign accept      = pix_i.valid && !q_full_i;
  assign q_push_o    = accept;

  // bytes of filtered image data: (3 * width + 1) * height
  assign wp1     = (DIM_BITS+2)'({w_use, 1'b0}) + (DIM_BITS+2)'(w_use) + (DIM_BITS+2)'(1);
  assign q_raw_o = RAW_W'(wp1) * RAW_W'(h_use);

  assign q_ctl_o    = '{start: start, col0: (col_q == '0), last: last};
  assign q_pix_o    = {pix_i.red, pix_i.green, pix_i.blue};
  assign q_width_o  = w_use;
  assign q_height_o = h_use;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= DIM_BITS'(2);
      height_q  <= DIM_BITS'(1);
      used_w_q  <= DIM_BITS'(2);
      used_h_q  <= DIM_BITS'(1);
      started_q <= 1'b0;
      col_q     <= '0;
      row_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
          CFG_IMAGE_HEIGHT: height_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept) begin
        used_w_q <= w_use;
        used_h_q <= h_use;
        if (last) begin
          started_q <= 1'b0;
          col_q     <= '0;
          row_q     <= '0;
        end else begin
          started_q <= 1'b1;
          col_q     <= wrap ? '0 : col_nx;
          row_q     <= row_nx;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/pse_queue.sv -----
`default_nettype none

module pse_queue #(
  parameter int unsigned W = 8
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire logic [W-1:0] data_i,
  output logic              full_o,
  input  wire logic         pop_i,
  output logic              valid_o,
  output logic [W-1:0]      data_o
);

  logic [W-1:0] mem_q [2];
  logic         wptr_q, rptr_q;
  logic [1:0]   cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) wptr_q <= !wptr_q;
      if (pop_i)  rptr_q <= !rptr_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

`default_nettype wire

// ----- design/pse_div.sv -----
`default_nettype none

// division by a constant through a reciprocal multiply, quotient registered on start
module pse_div #(
  parameter int unsigned N_W     = 17,
  parameter int unsigned DIVISOR = 65535,
  localparam int unsigned SH     = N_W + $clog2(DIVISOR),
  localparam int unsigned M_W    = N_W + 1,
  localparam int unsigned P_W    = N_W + M_W
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire logic [N_W-1:0] dividend_i,
  output logic [N_W-1:0]      quot_o
);

  // ceil(2^SH / DIVISOR) gives the exact quotient for every dividend below 2^N_W
  localparam logic [63:0]    RECIP_WIDE = ((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [M_W-1:0] RECIP      = M_W'(RECIP_WIDE);

  logic [P_W-1:0] prod;
  logic [N_W-1:0] quot_q;

  assign prod   = P_W'(dividend_i) * P_W'(RECIP);
  assign quot_o = quot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quot_q <= '0;
    end else if (start_i) begin
      quot_q <= N_W'(prod >> SH);
    end
  end

endmodule

`default_nettype wire

// ----- design/pse_back.sv -----
`default_nettype none

module pse_back
  import pse_pkg::*;
#(
  parameter int unsigned DIM_BITS         = PSE_DIM_BITS,
  parameter int unsigned STORED_BLOCK_MAX = PSE_BLOCK_MAX,
  localparam int unsigned RAW_W           = 2 * DIM_BITS + 2,
  localparam int unsigned DIV_W           = ((RAW_W > 16) ? RAW_W : 16) + 1
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                q_valid_i,
  output logic                     q_pop_o,
  input  wire pse_ctl_t            q_ctl_i,
  input  wire logic [23:0]         q_pix_i,
  input  wire logic [DIM_BITS-1:0] q_width_i,
  input  wire logic [DIM_BITS-1:0] q_height_i,
  input  wire logic [RAW_W-1:0]    q_raw_i,
  pse_byte_if.source               byte_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_HEAD = 2'd1;
  localparam logic [1:0] ST_RAW  = 2'd2;
  localparam logic [1:0] ST_TAIL = 2'd3;

  logic [1:0]          state_q;
  logic [5:0]          hidx_q;
  logic [4:0]          tidx_q;
  logic [1:0]          step_q, hsel;
  logic [2:0]          hb_q;
  logic [23:0]         pix_q;
  logic                last_q;
  logic [DIM_BITS-1:0] w_q, h_q;
  logic [RAW_W-1:0]    raw_left_q;
  logic [15:0]         block_left_q, size, inv, adler_lo_q, adler_hi_q, adler_lo_nx;
  logic [31:0]         crc_q, crc_n, idat_len, adler;
  logic [15:0]         w16, h16;
  logic                ov_q, orun_q, ofile_q;
  logic [7:0]          obyte_q;
  logic                blk_final, can_load, emit, take;
  logic [7:0]          byte_d;
  logic                feed, restart, have, rl, fl, done_item;
  logic [DIV_W-1:0]    quot;

  pse_div #(
    .N_W     (DIV_W),
    .DIVISOR (STORED_BLOCK_MAX)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (take && q_ctl_i.start),
    .dividend_i (DIV_W'(q_raw_i) + DIV_W'(STORED_BLOCK_MAX - 1)),
    .quot_o     (quot)
  );

  assign blk_final   = (32'(raw_left_q) <= 32'(STORED_BLOCK_MAX));
  assign size        = blk_final ? 16'(raw_left_q) : 16'(STORED_BLOCK_MAX);
  assign inv         = ~size;
  assign idat_len    = 32'd6 + 32'(quot) * 32'd5 + 32'(raw_left_q);
  assign crc_n       = ~crc_q;
  assign adler       = {adler_hi_q, adler_lo_q};
  assign adler_lo_nx = adler_add(adler_lo_q, {8'd0, byte_d});
  assign w16         = 16'(w_q);
  assign h16         = 16'(h_q);
  assign hsel        = hidx_q[1:0] - 2'd1;

  always_comb begin
    byte_d    = 8'd0;
    feed      = 1'b0;
    restart   = 1'b0;
    have      = 1'b1;
    rl        = 1'b0;
    fl        = 1'b0;
    done_item = 1'b0;
    unique case (state_q)
      ST_HEAD: begin
        case (hidx_q) inside
          [6'd0:6'd7]:   byte_d = PNG_SIG[{~hidx_q[2:0], 3'b000} +: 8];
          6'd11:         byte_d = IHDR_LEN;
          [6'd12:6'd15]: byte_d = CHUNK_IHDR[{~hidx_q[1:0], 3'b000} +: 8];
          6'd18:         byte_d = w16[15:8];
          6'd19:         byte_d = w16[7:0];
          6'd22:         byte_d = h16[15:8];
          6'd23:         byte_d = h16[7:0];
          6'd24:         byte_d = IHDR_DEPTH;
          6'd25:         byte_d = IHDR_COLOR;
          [6'd29:6'd32]: byte_d = crc_n[{~hsel, 3'b000} +: 8];
          [6'd33:6'd36]: byte_d = idat_len[{~hsel, 3'b000} +: 8];
          [6'd37:6'd40]: byte_d = CHUNK_IDAT[{~hsel, 3'b000} +: 8];
          6'd41:         byte_d = ZLIB_CMF;
          6'd42:         byte_d = ZLIB_FLG;
          default:       byte_d = 8'd0;
        endcase
        restart = (hidx_q == 6'd12) || (hidx_q == 6'd37);
        feed    = ((hidx_q >= 6'd12) && (hidx_q <= 6'd28)) || (hidx_q >= 6'd37);
      end
      ST_RAW: begin
        feed = 1'b1;
        if (block_left_q == '0) begin
          case (hb_q)
            3'd0:    byte_d = {7'd0, blk_final};
            3'd1:    byte_d = size[7:0];
            3'd2:    byte_d = size[15:8];
            3'd3:    byte_d = inv[7:0];
            3'd4:    byte_d = inv[15:8];
            default: byte_d = 8'd0;
          endcase
        end else begin
          case (step_q)
            2'd0:    byte_d = 8'd0;
            2'd1:    byte_d = pix_q[23:16];
            2'd2:    byte_d = pix_q[15:8];
            default: byte_d = pix_q[7:0];
          endcase
          if ((step_q == 2'd3) && !last_q) begin
            rl        = 1'b1;
            done_item = 1'b1;
          end
        end
      end
      ST_TAIL: begin
        case (tidx_q) inside
          [5'd0:5'd3]:   byte_d = adler[{~tidx_q[1:0], 3'b000} +: 8];
          [5'd4:5'd7]:   byte_d = crc_n[{~tidx_q[1:0], 3'b000} +: 8];
          [5'd12:5'd15]: byte_d = CHUNK_IEND[{~tidx_q[1:0], 3'b000} +: 8];
          [5'd16:5'd19]: byte_d = crc_n[{~tidx_q[1:0], 3'b000} +: 8];
          default:       byte_d = 8'd0;
        endcase
        restart = (tidx_q == 5'd12);
        feed    = (tidx_q <= 5'd3) || ((tidx_q >= 5'd12) && (tidx_q <= 5'd15));
        if (tidx_q == 5'd19) begin
          rl        = 1'b1;
          fl        = 1'b1;
          done_item = 1'b1;
        end
      end
      default: have = 1'b0;
    endcase
  end

  assign can_load = !ov_q || byte_o.ready;
  assign emit     = can_load && have;
  assign take     = q_valid_i && ((state_q == ST_IDLE) || (emit && done_item));
  assign q_pop_o  = take;

  assign byte_o.valid     = ov_q;
  assign byte_o.out_byte  = obyte_q;
  assign byte_o.run_last  = orun_q;
  assign byte_o.file_last = ofile_q;

  always_ff @(posedge clk_i) begin
    if (emit) begin
      obyte_q <= byte_d;
      orun_q  <= rl;
      ofile_q <= fl;
    end
    if (take) begin
      pix_q  <= q_pix_i;
      last_q <= q_ctl_i.last;
      if (q_ctl_i.start) begin
        w_q <= q_width_i;
        h_q <= q_height_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      ov_q         <= 1'b0;
      hidx_q       <= '0;
      tidx_q       <= '0;
      step_q       <= '0;
      hb_q         <= '0;
      raw_left_q   <= '0;
      block_left_q <= '0;
      adler_lo_q   <= 16'd1;
      adler_hi_q   <= '0;
      crc_q        <= CRC_INIT;
    end else begin
      if (can_load) ov_q <= emit;
      if (emit && feed) crc_q <= crc_byte(restart ? CRC_INIT : crc_q, byte_d);

      if (emit) begin
        unique case (state_q)
          ST_HEAD: begin
            if (hidx_q == 6'd42) begin
              state_q <= ST_RAW;
              hidx_q  <= '0;
            end else begin
              hidx_q <= hidx_q + 6'd1;
            end
          end
          ST_RAW: begin
            if (block_left_q == '0) begin
              if (hb_q == 3'd4) begin
                hb_q         <= '0;
                block_left_q <= size;
              end else begin
                hb_q <= hb_q + 3'd1;
              end
            end else begin
              block_left_q <= block_left_q - 16'd1;
              if (raw_left_q != '0) raw_left_q <= raw_left_q - RAW_W'(1);
              adler_lo_q <= adler_lo_nx;
              adler_hi_q <= adler_add(adler_hi_q, adler_lo_nx);
              if (step_q == 2'd3) begin
                if (last_q) begin
                  state_q <= ST_TAIL;
                  tidx_q  <= '0;
                end
              end else begin
                step_q <= step_q + 2'd1;
              end
            end
          end
          ST_TAIL: tidx_q <= tidx_q + 5'd1;
          default: ;
        endcase
        if (done_item && !take) state_q <= ST_IDLE;
      end

      if (take) begin
        step_q <= q_ctl_i.col0 ? 2'd0 : 2'd1;
        if (q_ctl_i.start) begin
          state_q      <= ST_HEAD;
          hidx_q       <= '0;
          hb_q         <= '0;
          raw_left_q   <= q_raw_i;
          block_left_q <= '0;
          adler_lo_q   <= 16'd1;
          adler_hi_q   <= '0;
        end else begin
          state_q <= ST_RAW;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- sim/tb_png_stored_stream_encoder_core.sv -----
`default_nettype none

module tb_png_stored_stream_encoder_core;
  import pse_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       file_last;
  } file_byte_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = CFG_IMAGE_WIDTH;
  logic [PSE_DIM_BITS-1:0] cfg_data_i = '0;

  pse_pix_if pix_if ();
  pse_byte_if byte_if ();

  png_stored_stream_encoder_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pix_i      (pix_if.sink),
    .byte_o     (byte_if.source),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // encoder state mirrored in the testbench
  logic [13:0] reg_width = 14'd2, reg_height = 14'd1;
  logic [13:0] cur_width = 14'd2, cur_height = 14'd1;
  logic        in_file;
  logic [13:0] col_cnt, row_cnt;
  logic [15:0] block_left;
  logic [31:0] raw_left;
  logic [15:0] sum_lo, sum_hi;
  logic [31:0] idat_crc;

  file_byte_t  expected_bytes[$];
  file_byte_t  pixel_bytes[$];
  int          mismatches = 0;
  int          hold_cycles = 0;
  bit          stall_enable = 1'b1;
  int          burst_max = 8;

  // bitwise crc-32, written independently of the package helper
  function automatic logic [31:0] crc32_step(logic [31:0] c, logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ 32'hedb88320) : (r >> 1);
    end
    return r;
  endfunction

  task automatic emit(logic [7:0] b);
    pixel_bytes.push_back('{data: b, run_last: 1'b0, file_last: 1'b0});
  endtask

  task automatic emit_be32(logic [31:0] v);
    for (int i = 3; i >= 0; i--) begin
      emit(v[i*8 +: 8]);
    end
  endtask

  task automatic emit_idat(logic [7:0] b);
    idat_crc = crc32_step(idat_crc, b);
    emit(b);
  endtask

  // raw filtered byte with stored block framing and adler update
  task automatic emit_raw(logic [7:0] b);
    logic [31:0] blk;
    logic [15:0] inv;
    logic [16:0] s;
    if (block_left == 0) begin
      blk = (raw_left > 65535) ? 32'd65535 : raw_left;
      inv = ~blk[15:0];
      emit_idat((raw_left <= 65535) ? 8'd1 : 8'd0);
      emit_idat(blk[7:0]);
      emit_idat(blk[15:8]);
      emit_idat(inv[7:0]);
      emit_idat(inv[15:8]);
      block_left = blk[15:0];
    end
    emit_idat(b);
    if (block_left != 0) block_left--;
    if (raw_left != 0) raw_left--;
    s = sum_lo + b;
    if (s >= 65521) s -= 65521;
    sum_lo = s[15:0];
    s = sum_hi + sum_lo;
    if (s >= 65521) s -= 65521;
    sum_hi = s[15:0];
  endtask

  task automatic emit_chunk_type(logic [31:0] t, inout logic [31:0] c);
    for (int i = 3; i >= 0; i--) begin
      c = crc32_step(c, t[i*8 +: 8]);
      emit(t[i*8 +: 8]);
    end
  endtask

  task automatic open_file();
    logic [7:0]  hdr[13];
    logic [31:0] c;
    longint      raw, nblk;
    cur_width = (reg_width < 2) ? 14'd2 : reg_width;
    cur_height = (reg_height < 1) ? 14'd1 : reg_height;
    raw = (longint'(cur_width) * 3 + 1) * cur_height;
    nblk = (raw + 65534) / 65535;
    for (int i = 7; i >= 0; i--) emit(PNG_SIG[i*8 +: 8]);
    hdr = '{default: 8'd0};
    hdr[2] = cur_width[13:8];
    hdr[3] = cur_width[7:0];
    hdr[6] = cur_height[13:8];
    hdr[7] = cur_height[7:0];
    hdr[8] = 8'd8;
    hdr[9] = 8'd2;
    c = '1;
    emit_be32(32'd13);
    emit_chunk_type(32'h49484452, c);
    for (int i = 0; i < 13; i++) begin
      c = crc32_step(c, hdr[i]);
      emit(hdr[i]);
    end
    emit_be32(~c);
    idat_crc = '1;
    emit_be32(32'(2 + nblk * 5 + raw + 4));
    emit_chunk_type(32'h49444154, idat_crc);
    emit_idat(8'h78);
    emit_idat(8'h01);
    in_file = 1'b1;
    col_cnt = '0;
    row_cnt = '0;
    block_left = '0;
    raw_left = 32'(raw);
    sum_lo = 16'd1;
    sum_hi = '0;
  endtask

  task automatic reset_model();
    in_file = 1'b0;
    col_cnt = '0;
    row_cnt = '0;
    block_left = '0;
    raw_left = '0;
    sum_lo = 16'd1;
    sum_hi = '0;
    idat_crc = '1;
  endtask

  // bytes one pixel produces, queued for the checker
  task automatic predict_pixel_bytes(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    logic [31:0] c, adl;
    pixel_bytes.delete();
    if (!in_file) open_file();
    if (col_cnt == 0) emit_raw(8'd0);
    emit_raw(r);
    emit_raw(g);
    emit_raw(b);
    col_cnt++;
    if (col_cnt >= cur_width) begin
      col_cnt = '0;
      row_cnt++;
    end
    if (row_cnt >= cur_height) begin
      adl = {sum_hi, sum_lo};
      for (int i = 3; i >= 0; i--) emit_idat(adl[i*8 +: 8]);
      emit_be32(~idat_crc);
      c = '1;
      emit_be32(32'd0);
      emit_chunk_type(32'h49454e44, c);
      emit_be32(~c);
      pixel_bytes[$].file_last = 1'b1;
      reset_model();
    end
    pixel_bytes[$].run_last = 1'b1;
    foreach (pixel_bytes[i]) expected_bytes.push_back(pixel_bytes[i]);
  endtask

  // ---------------------------------------------------------------- sender side

  initial begin
    pix_if.valid = 1'b0;
    pix_if.red = '0;
    pix_if.green = '0;
    pix_if.blue = '0;
  end

  // offer one pixel, wait for its handshake; random gaps before bursts
  int burst_left = 0;
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 4);
      if (gap != 0) begin
        pix_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, burst_max);
    end
    pix_if.valid <= 1'b1;
    pix_if.red <= r;
    pix_if.green <= g;
    pix_if.blue <= b;
    predict_pixel_bytes(r, g, b);
    do @(posedge clk_i); while (!pix_if.ready);
    burst_left--;
  endtask

  task automatic idle_sender();
    pix_if.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    idle_sender();
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [13:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_IMAGE_WIDTH) reg_width = val;
    else reg_height = val;
  endtask

  task automatic send_random_pixel();
    send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic send_image(int n);
    for (int i = 0; i < n; i++) send_random_pixel();
  endtask

  // ---------------------------------------------------------------- receiver side

  initial byte_if.ready = 1'b0;

  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      byte_if.ready <= 1'b0;
    end else if (stall_enable) begin
      // stall pattern of its own: independent random stalls, with ready mostly high
      byte_if.ready <= ($urandom_range(0, 15) < 11);
    end else begin
      byte_if.ready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    file_byte_t got, want;
    if (rst_ni && byte_if.valid && byte_if.ready) begin
      got = '{data: byte_if.out_byte, run_last: byte_if.run_last,
              file_last: byte_if.file_last};
      if (expected_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected byte %h (run_last %b file_last %b)",
                                       got.data, got.run_last, got.file_last);
      end else begin
        want = expected_bytes.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("byte mismatch: expected %h/%b/%b got %h/%b/%b", want.data,
                     want.run_last, want.file_last, got.data, got.run_last, got.file_last);
        end
      end
    end
  end

  // ---------------------------------------------------------------- tests

  // reset-default 2x1 image, field extremes and all-bit toggling
  task automatic test_default_size();
    send_pixel(8'h00, 8'hff, 8'h00);
    send_pixel(8'hff, 8'h00, 8'hff);
    drain();
  endtask

  // width and height below range are clamped to 2 and 1
  task automatic test_clamped_size();
    write_reg(CFG_IMAGE_WIDTH, 14'd0);
    write_reg(CFG_IMAGE_HEIGHT, 14'd0);
    send_pixel(8'haa, 8'h55, 8'hff);
    send_pixel(8'h55, 8'haa, 8'h00);
    drain();
    write_reg(CFG_IMAGE_WIDTH, 14'd1);
    write_reg(CFG_IMAGE_HEIGHT, 14'd2);
    send_image(4);
    drain();
  endtask

  // register writes during a file take effect only with the next file
  task automatic test_register_latching();
    write_reg(CFG_IMAGE_WIDTH, 14'd3);
    write_reg(CFG_IMAGE_HEIGHT, 14'd2);
    send_image(2);
    drain();
    write_reg(CFG_IMAGE_WIDTH, 14'd2);
    write_reg(CFG_IMAGE_HEIGHT, 14'd1);
    send_image(4);
    drain();
  endtask

  // maximum dimensions reach ihdr, the idat length and a non-final block header;
  // a whole image would be far too long, so only the opening pixels are checked
  task automatic test_max_width();
    write_reg(CFG_IMAGE_WIDTH, 14'd16383);
    write_reg(CFG_IMAGE_HEIGHT, 14'd16383);
    send_image(48);
    drain();
  endtask

  // long receiver hold while the sender keeps offering, then a run with no receiver stalls and long sender bursts
  task automatic test_backpressure();
    write_reg(CFG_IMAGE_WIDTH, 14'd5);
    write_reg(CFG_IMAGE_HEIGHT, 14'd4);
    hold_cycles = 400;
    send_image(20);
    idle_sender();
    while (expected_bytes.size() != 0) @(posedge clk_i);
    stall_enable = 1'b0;
    burst_max = 40;
    send_image(20);
    stall_enable = 1'b1;
    burst_max = 8;
    drain();
  endtask

  // random small images
  task automatic test_random_images();
    int w, h;
    write_reg(CFG_IMAGE_WIDTH, 14'd2);
    write_reg(CFG_IMAGE_HEIGHT, 14'd16383);
    write_reg(CFG_IMAGE_HEIGHT, 14'd3);
    for (int k = 0; k < 12; k++) begin
      w = $urandom_range(2, 6);
      h = $urandom_range(1, 4);
      write_reg(CFG_IMAGE_WIDTH, 14'(w));
      write_reg(CFG_IMAGE_HEIGHT, 14'(h));
      send_image(w * h);
      drain();
    end
  endtask

  initial begin
    reset_model();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_size();
    test_clamped_size();
    test_register_latching();
    test_backpressure();
    test_random_images();
    test_max_width();
    if (mismatches == 0 && expected_bytes.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
design/pse_pkg.sv
design/pse_if.sv
design/pse_front.sv
design/pse_queue.sv
design/pse_div.sv
design/pse_back.sv
design/png_stored_stream_encoder_core.sv
sim/tb_png_stored_stream_encoder_core.sv
